// ===== design/sla_pkg.sv =====
// ---------------------------------------------------------------------------
// sla_pkg: shared types and constants of the serial line assembler
// Character codes and the command/status bundles between control and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package sla_pkg;

   // special characters
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_BS  = 8'h08;
   localparam logic [7:0] CHAR_DEL = 8'h7F;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // request kinds carried in tuser
   localparam logic ACT_BYTE       = 1'b0;
   localparam logic ACT_READ_CLEAR = 1'b1;

   // reset value of the destination size register
   localparam logic [7:0] CAPACITY_RESET = 8'd255;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;      // latch the accepted request
      logic do_status;    // emit the overflow status and clear the flag
      logic do_erase;     // drop the last character
      logic do_store;     // store a character or take the overflow path
      logic rd_first;     // read entry 0
      logic load_first;   // hold entry 0 as pending, read entry 1
      logic emit_char;    // send the pending character, advance or finish
      logic emit_empty;   // send one empty result and clear the line
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_status;    // request is a read-and-clear
      logic is_line_end;  // CR or LF
      logic is_erase;     // backspace or DEL
      logic len_zero;     // line holds no character
      logic first_stop;   // nothing is copied from this line
      logic run_last;     // the pending character ends the run
      logic out_free;     // output register can take a result
   } status_type;

endpackage

`default_nettype wire

// ===== design/sla_ctrl.sv =====
// ---------------------------------------------------------------------------
// sla_ctrl: controller of the serial line assembler
// Sequences decode, line store updates and the emission of a completed line.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire sla_pkg::status_type stat,
   output sla_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_FIRST  = 3'd2;
   localparam logic [2:0] ST_NEXT   = 3'd3;
   localparam logic [2:0] ST_EMPTY  = 3'd4;
   localparam logic [2:0] ST_STATUS = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_status) begin
               state_in = ST_STATUS;
            end else if (stat.is_line_end) begin
               if (stat.len_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = ST_FIRST;
               end
            end else if (stat.is_erase) begin
               cmd.do_erase = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.do_store = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_FIRST: begin
            if (stat.first_stop) begin
               state_in = ST_EMPTY;
            end else begin
               cmd.load_first = 1'b1;
               state_in       = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (stat.out_free) begin
               cmd.emit_char = 1'b1;
               if (stat.run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (stat.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (stat.out_free) begin
               cmd.do_status = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/sla_datapath.sv =====
// ---------------------------------------------------------------------------
// sla_datapath: datapath of the serial line assembler
// Line store memory, length and flag registers, output register.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_datapath #(
   parameter int LINE_CAPACITY = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [0:0]       req_tuser,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             csr_valid,
   input  wire logic [7:0]       csr_data,
   input  wire sla_pkg::cmd_type cmd,
   output sla_pkg::status_type   stat,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);

   logic [7:0]       store_mem [LINE_CAPACITY];
   logic             req_action_ff;
   logic [7:0]       req_byte_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             flag_ff;
   logic             flag_in;
   logic [7:0]       cap_ff;
   logic [LEN_W-1:0] idx_ff;
   logic [7:0]       pend_ff;
   logic [7:0]       rd_ff;
   logic             rd_en;
   logic [LEN_W-1:0] rd_addr;
   logic             store_full;
   logic             out_load;
   logic [7:0]       out_char;
   logic             out_valid_char;
   logic             out_last;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_char_ff;
   logic             rsp_cvalid_ff;
   logic             rsp_last_ff;
   logic             rsp_flag_ff;

   // captured request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_action_ff <= req_tuser[0];
         req_byte_ff   <= req_tdata;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= sla_pkg::CAPACITY_RESET;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   // store full when one more character would fill it
   assign store_full = ({1'b0, len_ff} + (LEN_W+1)'(1)) >= (LEN_W+1)'(LINE_CAPACITY);

   // status towards the controller
   always_comb begin
      stat.is_status   = (req_action_ff == sla_pkg::ACT_READ_CLEAR);
      stat.is_line_end = (req_byte_ff == sla_pkg::CHAR_CR) || (req_byte_ff == sla_pkg::CHAR_LF);
      stat.is_erase    = (req_byte_ff == sla_pkg::CHAR_BS) ||
                         (req_byte_ff == sla_pkg::CHAR_DEL);
      stat.len_zero    = (len_ff == '0);
      stat.first_stop  = (rd_ff == sla_pkg::CHAR_NUL) || (cap_ff <= 8'd1);
      stat.run_last    = (({1'b0, idx_ff} + (LEN_W+1)'(1)) >= {1'b0, len_ff}) ||
                         ((9'(idx_ff) + 9'd2) >= {1'b0, cap_ff}) ||
                         (rd_ff == sla_pkg::CHAR_NUL);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // line length and overflow flag
   always_comb begin
      len_in  = len_ff;
      flag_in = flag_ff;
      if (cmd.do_erase && (len_ff != '0)) begin
         len_in = len_ff - LEN_W'(1);
      end
      if (cmd.do_store) begin
         if (store_full) begin
            len_in  = '0;
            flag_in = 1'b1;
         end else begin
            len_in = len_ff + LEN_W'(1);
         end
      end
      if (cmd.emit_empty || (cmd.emit_char && stat.run_last)) begin
         len_in = '0;
      end
      if (cmd.do_status) begin
         flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         flag_ff <= flag_in;
      end
   end

   // line store write
   always_ff @(posedge clock) begin
      if (cmd.do_store && !store_full) begin
         store_mem[len_ff] <= req_byte_ff;
      end
   end

   // line store read, one entry ahead of the pending character
   always_comb begin
      rd_en   = cmd.rd_first || cmd.load_first || (cmd.emit_char && !stat.run_last);
      rd_addr = idx_ff + LEN_W'(2);
      if (cmd.rd_first) begin
         rd_addr = '0;
      end else if (cmd.load_first) begin
         rd_addr = LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   // pending character and its index
   always_ff @(posedge clock) begin
      if (cmd.load_first) begin
         pend_ff <= rd_ff;
         idx_ff  <= '0;
      end else if (cmd.emit_char && !stat.run_last) begin
         pend_ff <= rd_ff;
         idx_ff  <= idx_ff + LEN_W'(1);
      end
   end

   // output register
   assign out_load       = cmd.emit_char || cmd.emit_empty || cmd.do_status;
   assign out_char       = cmd.emit_char ? pend_ff : sla_pkg::CHAR_NUL;
   assign out_valid_char = cmd.emit_char;
   assign out_last       = cmd.emit_char ? stat.run_last : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_char_ff   <= out_char;
         rsp_cvalid_ff <= out_valid_char;
         rsp_last_ff   <= out_last;
         rsp_flag_ff   <= flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_flag_ff, rsp_char_ff};
   assign rsp_tuser  = rsp_cvalid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/serial_line_assembler.sv =====
// ---------------------------------------------------------------------------
// serial_line_assembler: command line builder with backspace editing
// Collects received bytes into a line and emits completed lines per character.
// ---------------------------------------------------------------------------
// Usage
//   req channel: tuser[0] is the action (0 received byte, 1 read and clear
//   the overflow flag), tdata[7:0] the byte. One request is taken at a time;
//   tready is high only while the controller is idle.
//   rsp channel: one result per emitted character, tlast on the final one.
//   A read-and-clear and a line with nothing to copy give a single result.
//   csr channel: destination size, always ready, write only while idle.
// Sequence and throughput
//   A plain byte, backspace or ignored line end passes decode only, a status
//   request decode and the status state, which loads its result. A line goes
//   through decode, first read and the next state (the empty state if nothing
//   is copied); the next state sends one character per cycle while the
//   receiver does not stall, set by the single read port of the line store.
// Reset
//   Clears the line length, the overflow flag and the output valid, and
//   sets the destination size to 255. The line store is not cleared.
// Stall
//   A stalled receiver holds the result; the controller waits with the next
//   character and takes no new request until the line's last character is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_line_assembler #(
   parameter int LINE_CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] line_char, [8] overflow_flag
   output logic [0:0]       rsp_tuser,   // [0] char_valid
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // output_capacity
);

   sla_pkg::cmd_type    cmd;
   sla_pkg::status_type stat;

   assign csr_ready = 1'b1;

   // controller
   sla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   sla_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== design/sla_checker.sv =====
// ---------------------------------------------------------------------------
// sla_checker: port level checks of the serial line assembler
// Watches the result channel and request ready over time.
// ---------------------------------------------------------------------------
`default_nettype none

module sla_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // an empty or status result is always a whole run with a zero character
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("empty result not final");

   // no new request while a line is still being sent
   a_run_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during a line");

   // unused bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:9] == 7'd0))
      else $error("result padding not zero");

endmodule

bind serial_line_assembler sla_checker u_sla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/line_check_pkg.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// line_check_pkg: result tracking for the serial line assembler bench
// Keeps its own copy of the line editor state, works out the results that
// each accepted request causes and compares them with what the block sends.
// ---------------------------------------------------------------------------
package line_check_pkg;

   // one result as seen on the rsp channel
   typedef struct {
      logic [7:0] line_char;
      logic       char_valid;
      logic       run_last;
      logic       overflow_flag;
   } line_result_type;

   class line_scoreboard;
      logic [7:0]      held_chars[];
      int unsigned     held_count;
      logic            overflow_seen;
      logic [7:0]      dest_size;
      int unsigned     line_depth;
      line_result_type results_due[$];
      int              mismatches;
      int              checked;

      function new(int depth);
         line_depth    = depth;
         held_chars    = new[depth];
         held_count    = 0;
         overflow_seen = 1'b0;
         dest_size     = sla_pkg::CAPACITY_RESET;
         mismatches    = 0;
         checked       = 0;
      endfunction

      function void set_dest_size(logic [7:0] size);
         dest_size = size;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void add_result(logic [7:0] ch, logic valid, logic fin);
         line_result_type r;
         r.line_char     = ch;
         r.char_valid    = valid;
         r.run_last      = fin;
         r.overflow_flag = overflow_seen;
         results_due.push_back(r);
      endfunction

      // line editor update for one accepted request
      function void take_request(logic act, logic [7:0] data);
         int unsigned n;
         if (act == sla_pkg::ACT_READ_CLEAR) begin
            add_result(sla_pkg::CHAR_NUL, 1'b0, 1'b1);
            overflow_seen = 1'b0;
            return;
         end
         // line end: emit up to the first zero byte or the size limit
         if (data == sla_pkg::CHAR_CR || data == sla_pkg::CHAR_LF) begin
            if (held_count == 0) return;
            n = 0;
            while (n < held_count && n + 1 < dest_size &&
                   held_chars[n] != sla_pkg::CHAR_NUL) begin
               add_result(held_chars[n], 1'b1, 1'b0);
               n++;
            end
            if (n == 0) add_result(sla_pkg::CHAR_NUL, 1'b0, 1'b1);
            else results_due[results_due.size() - 1].run_last = 1'b1;
            held_count = 0;
            return;
         end
         // erase one character
         if (data == sla_pkg::CHAR_BS || data == sla_pkg::CHAR_DEL) begin
            if (held_count != 0) held_count--;
            return;
         end
         // store, or drop the line when the store would fill
         if (held_count + 1 < line_depth) begin
            held_chars[held_count] = data;
            held_count++;
         end else begin
            held_count    = 0;
            overflow_seen = 1'b1;
         end
      endfunction

      task report(string what);
         if (mismatches < 50) $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      // compare one accepted result with the oldest one due
      task check_result(logic [15:0] tdata, logic tuser, logic tlast);
         line_result_type want;
         if (results_due.size() == 0) begin
            report($sformatf("result %0d not due, tdata %h", checked, tdata));
            checked++;
            return;
         end
         want = results_due.pop_front();
         if (tdata[7:0] !== want.line_char)
            report($sformatf("result %0d line_char %h, want %h", checked, tdata[7:0],
                             want.line_char));
         if (tuser !== want.char_valid)
            report($sformatf("result %0d char_valid %b, want %b", checked, tuser,
                             want.char_valid));
         if (tlast !== want.run_last)
            report($sformatf("result %0d last %b, want %b", checked, tlast, want.run_last));
         if (tdata[8] !== want.overflow_flag)
            report($sformatf("result %0d overflow_flag %b, want %b", checked, tdata[8],
                             want.overflow_flag));
         if (tdata[15:9] !== 7'd0)
            report($sformatf("result %0d tdata pad bits %h", checked, tdata[15:9]));
         checked++;
      endtask

      task report_leftovers();
         if (results_due.size() != 0)
            report($sformatf("%0d results never arrived", results_due.size()));
      endtask
   endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: bench for the serial line assembler
// Sends directed and random byte streams (lines, edits, overflows, status
// requests) under several destination sizes and idle patterns, and checks
// every result against a predicted line editor.
// ---------------------------------------------------------------------------
module tb;

   localparam int LINE_DEPTH   = 32;
   localparam int SETTLE       = 8;
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [0:0]  req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'd0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int stall_id       = 0;
   int sent_count     = 0;

   line_check_pkg::line_scoreboard sb = new(LINE_DEPTH);

   serial_line_assembler #(.LINE_CAPACITY(LINE_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit roll_percent(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // printable or binary byte that is neither a line end nor an erase
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == sla_pkg::CHAR_CR || b == sla_pkg::CHAR_LF ||
             b == sla_pkg::CHAR_BS || b == sla_pkg::CHAR_DEL);
      return b;
   endfunction

   // offer one request, valid stays up for a following request
   task automatic send_request(input logic act, input logic [7:0] data);
      while (roll_percent(send_idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.take_request(act, data);
      sent_count++;
   endtask

   // drop valid and wait until every result has come, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [7:0] size);
      csr_valid <= 1'b1;
      csr_data  <= size;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      sb.set_dest_size(size);
   endtask

   task automatic start_phase(input logic [7:0] size, input int send_pct, input int stall_pct);
      wait_drained();
      write_capacity(size);
      send_idle_pct = send_pct;
      recv_stall_pct <= stall_pct;
   endtask

   // a line of random text with some erases, ended by CR or LF
   task automatic send_random_line(input int chars);
      int i;
      for (i = 0; i < chars; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_request(sla_pkg::ACT_BYTE,
                         $urandom_range(0, 1) ? sla_pkg::CHAR_BS : sla_pkg::CHAR_DEL);
         else
            send_request(sla_pkg::ACT_BYTE, text_byte());
      end
      send_request(sla_pkg::ACT_BYTE,
                   $urandom_range(0, 1) ? sla_pkg::CHAR_CR : sla_pkg::CHAR_LF);
   endtask

   // mostly well-formed lines, some status requests, noise and cut-off lines
   task automatic run_random_mix(input int goal);
      int stop_at;
      int pick;
      int i;
      stop_at = sent_count + goal;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 11);
         if (pick == 0) begin
            send_request(sla_pkg::ACT_READ_CLEAR, 8'($urandom_range(0, 255)));
         end else if (pick == 1) begin
            send_request(sla_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
         end else if (pick == 2) begin
            send_random_line($urandom_range(28, 34));
         end else if (pick == 3) begin
            for (i = 0; i < $urandom_range(1, 4); i++)
               send_request(sla_pkg::ACT_BYTE, text_byte());
         end else begin
            send_random_line($urandom_range(1, 8));
         end
      end
   endtask

   // result side: check, then pick tready for the next cycle
   initial begin
      int hold_left;
      int stall_seen;
      hold_left  = 0;
      stall_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser[0], rsp_tlast);
         if (stall_seen != stall_id) begin
            stall_seen = stall_id;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !roll_percent(recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready) || (csr_valid && csr_ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL serial_line_assembler");
      $finish;
   end

   // stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: largest destination size, no idling
      start_phase(sla_pkg::CAPACITY_RESET, 0, 0);
      // line end and erase on an empty line
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_LF);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_BS);
      // erase by backspace and by DEL, then a one-character line
      send_request(sla_pkg::ACT_BYTE, 8'h41);
      send_request(sla_pkg::ACT_BYTE, 8'hFF);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_BS);
      send_request(sla_pkg::ACT_BYTE, 8'h42);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_DEL);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);
      // zero byte first: nothing copied
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_NUL);
      send_request(sla_pkg::ACT_BYTE, 8'h31);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);
      // zero byte in the middle stops the run
      send_request(sla_pkg::ACT_BYTE, 8'h55);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_NUL);
      send_request(sla_pkg::ACT_BYTE, 8'hAA);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_LF);
      // status with the flag clear, byte field ignored
      send_request(sla_pkg::ACT_READ_CLEAR, 8'h00);
      send_request(sla_pkg::ACT_READ_CLEAR, 8'hFF);
      // low and high-bit characters
      send_request(sla_pkg::ACT_BYTE, 8'h01);
      send_request(sla_pkg::ACT_BYTE, 8'hFE);
      send_request(sla_pkg::ACT_BYTE, 8'h80);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);

      // store overflow, flag seen on a line, then read and cleared
      repeat (LINE_DEPTH) send_request(sla_pkg::ACT_BYTE, text_byte());
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);
      send_random_line(3);
      send_request(sla_pkg::ACT_READ_CLEAR, 8'h00);
      send_request(sla_pkg::ACT_READ_CLEAR, 8'h00);
      run_random_mix(2);

      // smallest destination size, idle sender
      start_phase(8'd1, 55, 0);
      run_random_mix(2);

      // short destination, stalling receiver, with a full drain in between
      start_phase(8'd5, 0, 55);
      run_random_mix(1);
      wait_drained();
      run_random_mix(1);

      // two-byte destination, both sides idling
      start_phase(8'd2, 21, 21);
      run_random_mix(2);

      // long receiver hold while requests keep coming
      start_phase(8'($urandom_range(3, 40)), 0, 0);
      stall_id <= stall_id + 1;
      send_request(sla_pkg::ACT_BYTE, 8'h41);
      send_request(sla_pkg::ACT_BYTE, 8'h42);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);
      send_request(sla_pkg::ACT_BYTE, 8'h43);
      send_request(sla_pkg::ACT_BYTE, sla_pkg::CHAR_CR);
      run_random_mix(2);

      // back to the largest size, both sides idling
      start_phase(8'd255, 21, 21);
      run_random_mix(2);

      wait_drained();
      sb.report_leftovers();
      if (sb.mismatches == 0)
         $display("PASS serial_line_assembler");
      else
         $display("FAIL serial_line_assembler");
      $finish;
   end

endmodule
